// File: hw/rtl/weekly_setpoint_scheduler_defines.svh
// Assertion macros used by the checker file of the scheduler.
`ifndef WEEKLY_SETPOINT_SCHEDULER_DEFINES_SVH
`define WEEKLY_SETPOINT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// File: hw/rtl/wss_pkg.sv
package wss_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 15;
  localparam int ENTRY_W     = 6;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_OVERRIDE = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  localparam logic [2:0] ST_HOLD     = 3'd0;
  localparam logic [2:0] ST_TRANS    = 3'd1;
  localparam logic [2:0] ST_RELOC    = 3'd2;
  localparam logic [2:0] ST_CLK_INV  = 3'd3;
  localparam logic [2:0] ST_ACCEPTED = 3'd4;

  localparam logic [2:0] DAY_SUNDAY = 3'd7;
  localparam logic [3:0] DAY_WRAP   = 4'd8;

  typedef struct packed {
    logic [2:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic signed [7:0] value;
  } wss_entry_t;

  typedef logic [KEY_W-1:0] wss_key_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    wss_entry_t       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } wss_ram_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [7:0]  setpoint;
    logic               setpoint_valid;
    logic               from_override;
    logic [ENTRY_W-1:0] current_entry;
  } wss_res_t;

  // Ordering key: day (4 bits), hour, minute.
  function automatic wss_key_t entry_key(wss_entry_t e);
    return {1'b0, e.day, e.hour, e.minute};
  endfunction

endpackage

// File: hw/rtl/wss_in_if.sv
interface wss_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [5:0]        entry_index;
  logic [2:0]        day;
  logic [4:0]        hour;
  logic [5:0]        minute;
  logic signed [7:0] value;
  logic              clock_valid;

  modport source (output valid, cmd, entry_index, day, hour, minute, value, clock_valid,
                  input ready);
  modport sink (input valid, cmd, entry_index, day, hour, minute, value, clock_valid,
                output ready);
  modport monitor (input valid, ready, cmd, entry_index, day, hour, minute, value,
                   clock_valid);
endinterface

// File: hw/rtl/wss_out_if.sv
interface wss_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [7:0] setpoint;
  logic              setpoint_valid;
  logic              from_override;
  logic [5:0]        current_entry;

  modport source (output valid, status, setpoint, setpoint_valid, from_override,
                  current_entry, input ready);
  modport sink (input valid, status, setpoint, setpoint_valid, from_override,
                current_entry, output ready);
  modport monitor (input valid, ready, status, setpoint, setpoint_valid, from_override,
                   current_entry);
endinterface

// File: hw/rtl/weekly_setpoint_scheduler.sv
// Channel   Dir  Handshake        Carries
// in_if     in   valid / ready    request: cmd, entry_index, day, hour, minute, value,
//                                 clock_valid
// out_if    out  valid / ready    result: status, setpoint, setpoint_valid,
//                                 from_override, current_entry
// cfg       in   cfg_we           entry_count (cfg_wdata), no read-back
//
// Load, override, unused command and invalid-clock requests go from accept straight
// to the result state (S_DONE). A valid tick reads the current and next entries
// and, when the table is searched, examines one entry per cycle up to the clamped count (at most 64).
// Reset (rst_n low, synchronous) clears the position and the override and sets the
// count to 1; the table itself holds garbage until loaded.
// A result held in the output register lets the next request in; its own result
// then waits in the sequencer until the output register drains.
module weekly_setpoint_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  wss_in_if.sink     in_if,
  wss_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);
  import wss_pkg::*;

  wss_ram_req_t ram_req;
  wss_entry_t   ram_rdata;
  logic         res_valid;
  wss_res_t     res;
  logic         res_take;

  logic         out_valid_r, out_valid_nxt;
  wss_res_t     out_res_r;

  // Schedule table: one write and one registered read per cycle.
  wss_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  // Sequencer: decode the request, read-modify the position and override state,
  // search the table when the tick lands outside the current window.
  wss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Hand the result over when the output register is empty or draining now.
  assign res_take = res_valid && (!out_valid_r || out_if.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold while stalled, load on handover.
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_res_r.status;
  assign out_if.setpoint       = out_res_r.setpoint;
  assign out_if.setpoint_valid = out_res_r.setpoint_valid;
  assign out_if.from_override  = out_res_r.from_override;
  assign out_if.current_entry  = out_res_r.current_entry;
endmodule

// File: hw/rtl/wss_ram.sv
module wss_ram (
  input  logic                  clk,
  input  wss_pkg::wss_ram_req_t req,
  output wss_pkg::wss_entry_t   rd_data
);
  import wss_pkg::*;

  wss_entry_t mem_r [MAX_ENTRIES];
  wss_entry_t rd_data_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// File: hw/rtl/wss_ctrl.sv
module wss_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  wss_in_if.sink                in_if,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_wdata,
  output wss_pkg::wss_ram_req_t ram_req,
  input  wss_pkg::wss_entry_t   ram_rdata,
  output logic                  res_valid,
  output wss_pkg::wss_res_t     res,
  input  logic                  res_take
);
  import wss_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_CUR = 3'd1;
  localparam logic [2:0] S_RD_NXT = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  entry_count_r;
  logic [IDX_W-1:0]  cur_idx_r, cur_idx_nxt;
  logic              ovr_act_r, ovr_act_nxt;
  logic signed [7:0] ovr_sp_r, ovr_sp_nxt;

  wss_key_t          tick_r, tick_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  nxt_r, nxt_nxt;
  logic              wrap_r, wrap_nxt;
  logic [IDX_W-1:0]  srch_r, srch_nxt;
  wss_key_t          cur_key_r, cur_key_nxt;
  logic signed [7:0] cur_val_r, cur_val_nxt;
  wss_res_t          res_r, res_nxt;

  logic [CNT_W-1:0]  n_eff;
  logic [IDX_W-1:0]  n_last;
  logic [IDX_W-1:0]  cur_eff;
  logic [CNT_W-1:0]  cur_inc;
  logic [CNT_W-1:0]  srch_inc;
  logic [2:0]        tick_day;
  wss_key_t          tick_in;
  wss_key_t          nkey;
  wss_key_t          rkey;
  logic              in_acc;
  logic              hold;

  // Clamp the count to 1..MAX_ENTRIES.
  always_comb begin
    if (entry_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (entry_count_r > CNT_W'(MAX_ENTRIES)) begin
      n_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      n_eff = entry_count_r;
    end
  end

  assign n_last   = IDX_W'(n_eff - CNT_W'(1));
  assign cur_eff  = ({1'b0, cur_idx_r} >= n_eff) ? '0 : cur_idx_r;
  assign cur_inc  = {1'b0, cur_eff} + CNT_W'(1);
  assign srch_inc = {1'b0, srch_r} + CNT_W'(1);
  assign tick_day = (in_if.day == 3'd0) ? DAY_SUNDAY : in_if.day;
  assign tick_in  = {1'b0, tick_day, in_if.hour, in_if.minute};
  assign nkey     = wrap_r ? {DAY_WRAP, ram_rdata.hour, ram_rdata.minute}
                           : entry_key(ram_rdata);
  assign rkey     = entry_key(ram_rdata);
  assign hold     = (tick_r == cur_key_r) || ((tick_r > cur_key_r) && (tick_r < nkey));

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign res_valid   = (state_r == S_DONE);
  assign res         = res_r;

  always_comb begin
    state_nxt   = state_r;
    cur_idx_nxt = cur_idx_r;
    ovr_act_nxt = ovr_act_r;
    ovr_sp_nxt  = ovr_sp_r;
    tick_nxt    = tick_r;
    cur_nxt     = cur_r;
    nxt_nxt     = nxt_r;
    wrap_nxt    = wrap_r;
    srch_nxt    = srch_r;
    cur_key_nxt = cur_key_r;
    cur_val_nxt = cur_val_r;
    res_nxt     = res_r;

    ram_req.we    = 1'b0;
    ram_req.waddr = in_if.entry_index[IDX_W-1:0];
    ram_req.wdata = '{day: in_if.day, hour: in_if.hour, minute: in_if.minute,
                      value: in_if.value};
    ram_req.re    = 1'b0;
    ram_req.raddr = cur_eff;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt.status         = ST_HOLD;
          res_nxt.setpoint       = '0;
          res_nxt.setpoint_valid = 1'b0;
          res_nxt.from_override  = 1'b0;
          res_nxt.current_entry  = ENTRY_W'(cur_idx_r);
          state_nxt              = S_DONE;
          case (in_if.cmd)
            CMD_LOAD: begin
              ram_req.we            = ({1'b0, in_if.entry_index} < CNT_W'(MAX_ENTRIES));
              cur_idx_nxt           = '0;
              res_nxt.status        = ST_ACCEPTED;
              res_nxt.current_entry = '0;
            end
            CMD_OVERRIDE: begin
              ovr_act_nxt    = 1'b1;
              ovr_sp_nxt     = in_if.value;
              res_nxt.status = ST_ACCEPTED;
            end
            CMD_TICK: begin
              if (!in_if.clock_valid) begin
                res_nxt.status = ST_CLK_INV;
              end else begin
                // Fetch the current entry; the next one follows.
                ram_req.re = 1'b1;
                tick_nxt   = tick_in;
                cur_nxt    = cur_eff;
                wrap_nxt   = !(cur_inc < n_eff);
                nxt_nxt    = (cur_inc < n_eff) ? cur_inc[IDX_W-1:0] : '0;
                state_nxt  = S_RD_CUR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD_CUR: begin
        cur_key_nxt   = rkey;
        cur_val_nxt   = ram_rdata.value;
        ram_req.re    = 1'b1;
        ram_req.raddr = nxt_r;
        state_nxt     = S_RD_NXT;
      end

      S_RD_NXT: begin
        state_nxt = S_DONE;
        if (hold) begin
          cur_idx_nxt            = cur_r;
          res_nxt.status         = ST_HOLD;
          res_nxt.setpoint_valid = 1'b1;
          res_nxt.from_override  = ovr_act_r;
          res_nxt.setpoint       = ovr_act_r ? ovr_sp_r : cur_val_r;
          res_nxt.current_entry  = ENTRY_W'(cur_r);
        end else if (tick_r == nkey) begin
          cur_idx_nxt            = nxt_r;
          ovr_act_nxt            = 1'b0;
          ovr_sp_nxt             = '0;
          res_nxt.status         = ST_TRANS;
          res_nxt.setpoint_valid = 1'b1;
          res_nxt.from_override  = 1'b0;
          res_nxt.setpoint       = ram_rdata.value;
          res_nxt.current_entry  = ENTRY_W'(nxt_r);
        end else begin
          // Walk the table from the first entry.
          ram_req.re    = 1'b1;
          ram_req.raddr = '0;
          srch_nxt      = '0;
          state_nxt     = S_SEARCH;
        end
      end

      S_SEARCH: begin
        if ((rkey >= tick_r) || (srch_inc == n_eff)) begin
          if ((rkey >= tick_r) && (srch_r != '0)) begin
            cur_idx_nxt = srch_r - IDX_W'(1);
          end else begin
            cur_idx_nxt = n_last;
          end
          res_nxt.status         = ST_RELOC;
          res_nxt.setpoint       = '0;
          res_nxt.setpoint_valid = 1'b0;
          res_nxt.from_override  = 1'b0;
          res_nxt.current_entry  = ENTRY_W'(cur_idx_nxt);
          state_nxt              = S_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = srch_inc[IDX_W-1:0];
          srch_nxt      = srch_inc[IDX_W-1:0];
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= CNT_W'(1);
      cur_idx_r     <= '0;
      ovr_act_r     <= 1'b0;
      ovr_sp_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      cur_idx_r <= cur_idx_nxt;
      ovr_act_r <= ovr_act_nxt;
      ovr_sp_r  <= ovr_sp_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_wdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    tick_r    <= tick_nxt;
    cur_r     <= cur_nxt;
    nxt_r     <= nxt_nxt;
    wrap_r    <= wrap_nxt;
    srch_r    <= srch_nxt;
    cur_key_r <= cur_key_nxt;
    cur_val_r <= cur_val_nxt;
    res_r     <= res_nxt;
  end
endmodule

// File: hw/rtl/wss_chk.sv
`include "weekly_setpoint_scheduler_defines.svh"

module wss_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        out_status,
  input logic signed [7:0] out_setpoint,
  input logic              out_setpoint_valid,
  input logic              out_from_override,
  input logic [5:0]        out_current_entry
);
  import wss_pkg::*;

  logic        in_acc;
  logic        out_stall;
  logic [18:0] out_payload;
  logic        out_no_sp;
  logic        out_ovr;
  logic        out_bare;

  assign in_acc      = in_valid && in_ready;
  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_status, out_setpoint, out_setpoint_valid, out_from_override,
                        out_current_entry};
  assign out_no_sp   = out_valid && !out_setpoint_valid;
  assign out_ovr     = out_valid && out_from_override;
  assign out_bare    = out_valid && (out_status == ST_RELOC || out_status == ST_CLK_INV ||
                                     out_status == ST_ACCEPTED);

  // One request at a time: ready drops right after an accept.
  `WSS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_acc, !in_ready)

  // A stalled result holds.
  `WSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_payload))

  // No setpoint carried means the setpoint field is zero and not an override.
  `WSS_ASSERT_NOW(a_no_sp_zero, clk, rst_n, out_no_sp, out_setpoint == 8'sd0 && !out_from_override)

  // Override only ever shows on a hold result.
  `WSS_ASSERT_NOW(a_ovr_on_hold, clk, rst_n, out_ovr, out_status == ST_HOLD && out_setpoint_valid)

  // Relocation, invalid clock and accepted results carry no setpoint.
  `WSS_ASSERT_NOW(a_status_no_sp, clk, rst_n, out_bare, !out_setpoint_valid)
endmodule

bind weekly_setpoint_scheduler wss_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_status         (out_if.status),
  .out_setpoint       (out_if.setpoint),
  .out_setpoint_valid (out_if.setpoint_valid),
  .out_from_override  (out_if.from_override),
  .out_current_entry  (out_if.current_entry)
);
